FILE: design/tpba_pkg.sv
// Shared types, codes and default sizes of the two-pool bitmap block allocator.
package tpba_pkg;

  localparam int ADDR_W    = 32;
  localparam int SIZE_W    = 16;
  localparam int INDEX_W   = 4;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 1;

  localparam int SMALL_BLOCK_BYTES_DEF = 32'h0200;
  localparam int BIG_BLOCK_BYTES_DEF   = 32'h0600;
  localparam int SMALL_BLOCKS_DEF      = 16;
  localparam int BIG_BLOCKS_DEF        = 16;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE           = 2'd0,
    ST_ALLOC_FAIL     = 2'd1,
    ST_FREE_UNMATCHED = 2'd2
  } status_e_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SMALL_BASE = 1'b0,
    CFG_BIG_BASE   = 1'b1
  } cfg_reg_e_t;

  // Strobes from the top level into one pool.
  typedef struct packed {
    logic take;   // mark the lowest free block used
    logic give;   // clear the block that matched the free address
  } pool_ctl_t;

  // What one pool reports for the item under way.
  typedef struct packed {
    logic               has_free;
    logic               hit;
    logic [INDEX_W-1:0] alloc_index;
    logic [ADDR_W-1:0]  alloc_address;
    logic [INDEX_W-1:0] hit_index;
  } pool_stat_t;

endpackage

FILE: design/tpba_if.sv
// Valid/ready channel interfaces for requests, results and register writes.
interface tpba_req_if;
  import tpba_pkg::*;
  logic              valid;
  logic              ready;
  logic              command;
  logic [SIZE_W-1:0] request_size;
  logic [ADDR_W-1:0] free_address;
  modport source (output valid, command, request_size, free_address, input ready);
  modport sink   (input valid, command, request_size, free_address, output ready);
endinterface

interface tpba_rsp_if;
  import tpba_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                pool;
  logic [INDEX_W-1:0]  block_index;
  logic [ADDR_W-1:0]   block_address;
  modport source (output valid, status, pool, block_index, block_address, input ready);
  modport sink   (input valid, status, pool, block_index, block_address, output ready);
endinterface

interface tpba_cfg_if;
  import tpba_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [ADDR_W-1:0]    wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

FILE: design/tpba_pool.sv
// One pool of fixed-size blocks: used bitmap, lowest-free search and address match.
module tpba_pool #(
  parameter int BLOCKS = 16,
  parameter int BYTES  = 512
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [tpba_pkg::ADDR_W-1:0]   base,
  input  logic [tpba_pkg::ADDR_W-1:0]   free_address,
  input  tpba_pkg::pool_ctl_t           ctl,
  output tpba_pkg::pool_stat_t          stat
);
  import tpba_pkg::*;

  localparam int IDX_W  = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int PROD_W = IDX_W + SIZE_W;

  logic [BLOCKS-1:0] used_r, used_nxt;
  logic              has_free;
  logic [IDX_W-1:0]  free_idx;
  logic              hit;
  logic [IDX_W-1:0]  hit_idx;
  logic [ADDR_W-1:0] offset;
  logic [PROD_W-1:0] prod;

  // Lowest clear bit of the used map.
  always_comb begin
    has_free = 1'b0;
    free_idx = '0;
    for (int i = BLOCKS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        has_free = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  // Block i starts at base + i*BYTES modulo 2^32, and i*BYTES never wraps, so a
  // match means the wrapped distance from the base equals one block's offset.
  assign offset = free_address - base;

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = BLOCKS - 1; i >= 0; i--) begin
      if (offset == ADDR_W'(i * BYTES)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign prod = PROD_W'(free_idx) * PROD_W'(BYTES);

  always_comb begin
    used_nxt = used_r;
    if (ctl.take && has_free) begin
      used_nxt[free_idx] = 1'b1;
    end
    if (ctl.give && hit) begin
      used_nxt[hit_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      used_r <= used_nxt;
    end
  end

  assign stat.has_free      = has_free;
  assign stat.hit           = hit;
  assign stat.alloc_index   = INDEX_W'(free_idx);
  assign stat.alloc_address = base + ADDR_W'(prod);
  assign stat.hit_index     = INDEX_W'(hit_idx);

endmodule

FILE: design/two_pool_bitmap_block_allocator.sv
// Top level of the two-pool bitmap block allocator.
//
//   channel  | direction | fields                                        | transfer when
//   ---------+-----------+-----------------------------------------------+-------------------
//   in_chan  | into      | command, request_size, free_address           | valid and ready
//   out_chan | out of    | status, pool, block_index, block_address      | valid and ready
//   cfg_chan | into      | reg_index, wdata                              | valid (always ready)
//
// Each request passes through the input register and then the result
// register, and its result is offered once it reaches the result register;
// a new request is taken in every cycle while the sink does not stall. A
// single decision step between the two registers picks the answer and also
// writes the used bitmaps.
// Reset (rst_n low at a clock edge) empties both registers, frees every
// block and clears both base registers. While the result register is held by
// a stalled sink, the input register holds too and in_chan.ready falls once
// it is full.
module two_pool_bitmap_block_allocator #(
  parameter int SMALL_BLOCK_BYTES = tpba_pkg::SMALL_BLOCK_BYTES_DEF,
  parameter int BIG_BLOCK_BYTES   = tpba_pkg::BIG_BLOCK_BYTES_DEF,
  parameter int SMALL_BLOCKS      = tpba_pkg::SMALL_BLOCKS_DEF,
  parameter int BIG_BLOCKS        = tpba_pkg::BIG_BLOCKS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  tpba_req_if.sink     in_chan,
  tpba_rsp_if.source   out_chan,
  tpba_cfg_if.sink     cfg_chan
);
  import tpba_pkg::*;

  // Base address registers; the user must write them only while the block is idle (not enforced here).
  logic [ADDR_W-1:0] small_base_r, big_base_r;

  // Input register.
  logic              s1_valid_r;
  logic              s1_cmd_r;
  logic [SIZE_W-1:0] s1_size_r;
  logic [ADDR_W-1:0] s1_addr_r;

  // Result register.
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                out_pool_r, out_pool_nxt;
  logic [INDEX_W-1:0]  out_index_r, out_index_nxt;
  logic [ADDR_W-1:0]   out_addr_r, out_addr_nxt;

  logic       advance;     // the item in the input register moves on this cycle
  logic       is_free;
  logic       size_ok;
  logic       want_small;
  logic       use_small;
  logic       use_big;
  pool_ctl_t  small_ctl, big_ctl;
  pool_stat_t small_stat, big_stat;

  assign advance          = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready    = !s1_valid_r || advance;
  assign cfg_chan.ready   = 1'b1;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      small_base_r <= '0;
      big_base_r   <= '0;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.reg_index)
        CFG_SMALL_BASE: small_base_r <= cfg_chan.wdata;
        CFG_BIG_BASE:   big_base_r   <= cfg_chan.wdata;
        default:        ;
      endcase
    end
  end

  // Input register: load on every transfer, empty when the item moves on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_cmd_r  <= in_chan.command;
      s1_size_r <= in_chan.request_size;
      s1_addr_r <= in_chan.free_address;
    end
  end

  tpba_pool #(
    .BLOCKS (SMALL_BLOCKS),
    .BYTES  (SMALL_BLOCK_BYTES)
  ) u_small_pool (
    .clk          (clk),
    .rst_n        (rst_n),
    .base         (small_base_r),
    .free_address (s1_addr_r),
    .ctl          (small_ctl),
    .stat         (small_stat)
  );

  tpba_pool #(
    .BLOCKS (BIG_BLOCKS),
    .BYTES  (BIG_BLOCK_BYTES)
  ) u_big_pool (
    .clk          (clk),
    .rst_n        (rst_n),
    .base         (big_base_r),
    .free_address (s1_addr_r),
    .ctl          (big_ctl),
    .stat         (big_stat)
  );

  // A size of zero or beyond a big block cannot be served. Sizes that fit a
  // small block go to the small pool first and spill to the big pool when it
  // is full; larger sizes go straight to the big pool.
  assign is_free    = (s1_cmd_r == CMD_FREE);
  assign size_ok    = (s1_size_r != '0) && (s1_size_r <= SIZE_W'(BIG_BLOCK_BYTES));
  assign want_small = (s1_size_r <= SIZE_W'(SMALL_BLOCK_BYTES));
  assign use_small  = size_ok && want_small && small_stat.has_free;
  assign use_big    = size_ok && !use_small && big_stat.has_free;

  // A free address that matches a small block is taken as that small block,
  // even when a big block starts at the same address.
  assign small_ctl.take = advance && !is_free && use_small;
  assign small_ctl.give = advance && is_free && small_stat.hit;
  assign big_ctl.take   = advance && !is_free && use_big;
  assign big_ctl.give   = advance && is_free && !small_stat.hit && big_stat.hit;

  // Result fields; every failure reports zeros besides its status.
  always_comb begin
    out_status_nxt = ST_ALLOC_FAIL;
    out_pool_nxt   = 1'b0;
    out_index_nxt  = '0;
    out_addr_nxt   = '0;
    if (is_free) begin
      if (small_stat.hit) begin
        out_status_nxt = ST_DONE;
        out_index_nxt  = small_stat.hit_index;
        out_addr_nxt   = s1_addr_r;
      end else if (big_stat.hit) begin
        out_status_nxt = ST_DONE;
        out_pool_nxt   = 1'b1;
        out_index_nxt  = big_stat.hit_index;
        out_addr_nxt   = s1_addr_r;
      end else begin
        out_status_nxt = ST_FREE_UNMATCHED;
      end
    end else if (use_small) begin
      out_status_nxt = ST_DONE;
      out_index_nxt  = small_stat.alloc_index;
      out_addr_nxt   = small_stat.alloc_address;
    end else if (use_big) begin
      out_status_nxt = ST_DONE;
      out_pool_nxt   = 1'b1;
      out_index_nxt  = big_stat.alloc_index;
      out_addr_nxt   = big_stat.alloc_address;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status_r <= out_status_nxt;
      out_pool_r   <= out_pool_nxt;
      out_index_r  <= out_index_nxt;
      out_addr_r   <= out_addr_nxt;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = out_status_r;
  assign out_chan.pool          = out_pool_r;
  assign out_chan.block_index   = out_index_r;
  assign out_chan.block_address = out_addr_r;

endmodule

FILE: design/tpba_checker.sv
// Port-level checks of the two-pool bitmap block allocator, bound to its top level.
module tpba_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [tpba_pkg::STATUS_W-1:0] status,
  input logic                          pool,
  input logic [tpba_pkg::INDEX_W-1:0]  block_index,
  input logic [tpba_pkg::ADDR_W-1:0]   block_address
);
  import tpba_pkg::*;

  // Requests taken whose results have not yet been delivered.
  logic [1:0] pending_r, pending_nxt;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_comb begin
    pending_nxt = pending_r;
    if (in_xfer && !out_xfer) begin
      pending_nxt = pending_r + 2'd1;
    end else if (!in_xfer && out_xfer) begin
      pending_nxt = pending_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(pool)
      && $stable(block_index) && $stable(block_address))
    else $error("result changed while stalled");

  a_fail_zeros: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_ALLOC_FAIL || status == ST_FREE_UNMATCHED)
      |-> !pool && block_index == '0 && block_address == '0)
    else $error("failed result carries block fields");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> status != 2'd3)
    else $error("unknown status code");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 2'd0)
    else $error("result offered with no request outstanding");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r == 2'd2 && !out_ready |-> !in_ready)
    else $error("request taken with both registers full");

endmodule

bind two_pool_bitmap_block_allocator tpba_checker u_tpba_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .status        (out_chan.status),
  .pool          (out_chan.pool),
  .block_index   (out_chan.block_index),
  .block_address (out_chan.block_address)
);

FILE: verif/two_pool_bitmap_block_allocator_tb.sv
// Self-checking testbench for the two-pool bitmap block allocator.
`timescale 1ns / 1ps

module two_pool_bitmap_block_allocator_tb;
  import tpba_pkg::*;

  localparam int SMALL_BYTES = SMALL_BLOCK_BYTES_DEF;
  localparam int BIG_BYTES   = BIG_BLOCK_BYTES_DEF;
  localparam int SMALL_COUNT = SMALL_BLOCKS_DEF;
  localparam int BIG_COUNT   = BIG_BLOCKS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 80;

  // One allocator answer as it leaves the result channel.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                pool;
    logic [INDEX_W-1:0]  block_index;
    logic [ADDR_W-1:0]   block_address;
  } alloc_answer_t;

  // Keeps its own copy of both bitmaps and both base registers, works out the
  // answer for every request transfer and holds the answers still owed.
  class allocator_scoreboard;
    logic [ADDR_W-1:0]      small_base;
    logic [ADDR_W-1:0]      big_base;
    logic [SMALL_COUNT-1:0] small_used;
    logic [BIG_COUNT-1:0]   big_used;
    alloc_answer_t          owed_answers[$];
    int                     failures;

    function new();
      small_base = '0;
      big_base   = '0;
      small_used = '0;
      big_used   = '0;
      failures   = 0;
    endfunction

    function void write_base(cfg_reg_e_t reg_sel, logic [ADDR_W-1:0] value);
      if (reg_sel == CFG_SMALL_BASE) small_base = value;
      else big_base = value;
    endfunction

    function logic [ADDR_W-1:0] small_addr(int idx);
      return small_base + ADDR_W'(idx * SMALL_BYTES);
    endfunction

    function logic [ADDR_W-1:0] big_addr(int idx);
      return big_base + ADDR_W'(idx * BIG_BYTES);
    endfunction

    // Works out the answer to an accepted request and updates the bitmaps.
    function void note_request(logic command, logic [SIZE_W-1:0] size,
                               logic [ADDR_W-1:0] addr);
      alloc_answer_t ans;
      int            hit;
      ans  = '0;
      hit  = -1;
      if (command == CMD_ALLOC) begin
        ans.status = ST_ALLOC_FAIL;
        if (size != 0 && size <= BIG_BYTES) begin
          if (size <= SMALL_BYTES) begin
            for (int i = 0; i < SMALL_COUNT; i++) begin
              if (!small_used[i]) begin
                hit = i;
                break;
              end
            end
            if (hit >= 0) begin
              small_used[hit]   = 1'b1;
              ans.status        = ST_DONE;
              ans.block_index   = INDEX_W'(hit);
              ans.block_address = small_addr(hit);
            end
          end
          // Large sizes, and small ones that found the small pool full.
          if (hit < 0) begin
            for (int i = 0; i < BIG_COUNT; i++) begin
              if (!big_used[i]) begin
                hit = i;
                break;
              end
            end
            if (hit >= 0) begin
              big_used[hit]     = 1'b1;
              ans.status        = ST_DONE;
              ans.pool          = 1'b1;
              ans.block_index   = INDEX_W'(hit);
              ans.block_address = big_addr(hit);
            end
          end
        end
      end else begin
        ans.status = ST_FREE_UNMATCHED;
        for (int i = 0; i < SMALL_COUNT; i++) begin
          if (small_addr(i) == addr) begin
            hit = i;
            break;
          end
        end
        if (hit >= 0) begin
          small_used[hit]   = 1'b0;
          ans.status        = ST_DONE;
          ans.block_index   = INDEX_W'(hit);
          ans.block_address = addr;
        end else begin
          for (int i = 0; i < BIG_COUNT; i++) begin
            if (big_addr(i) == addr) begin
              hit = i;
              break;
            end
          end
          if (hit >= 0) begin
            big_used[hit]     = 1'b0;
            ans.status        = ST_DONE;
            ans.pool          = 1'b1;
            ans.block_index   = INDEX_W'(hit);
            ans.block_address = addr;
          end
        end
      end
      owed_answers.push_back(ans);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic pool,
                               logic [INDEX_W-1:0] block_index,
                               logic [ADDR_W-1:0] block_address);
      alloc_answer_t exp;
      bit            bad;
      bad = 1'b0;
      if (owed_answers.size() == 0) begin
        $error("result transfer with no answer owed: status %0d pool %0d index %0d addr %h",
               status, pool, block_index, block_address);
        failures++;
        return;
      end
      exp = owed_answers.pop_front();
      if (status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, status);
        bad = 1'b1;
      end
      if (pool !== exp.pool) begin
        $error("pool: expected %0d, got %0d", exp.pool, pool);
        bad = 1'b1;
      end
      if (block_index !== exp.block_index) begin
        $error("block_index: expected %0d, got %0d", exp.block_index, block_index);
        bad = 1'b1;
      end
      if (block_address !== exp.block_address) begin
        $error("block_address: expected %h, got %h", exp.block_address, block_address);
        bad = 1'b1;
      end
      if (bad) failures++;
    endfunction

    function int owed();
      return owed_answers.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  tpba_req_if in_chan ();
  tpba_rsp_if out_chan ();
  tpba_cfg_if cfg_chan ();

  two_pool_bitmap_block_allocator u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  allocator_scoreboard sb = new();

  // Idling switches, and the length of a sink hold-off asked for by the
  // stimulus; the sink process picks the request up and counts it down.
  bit source_idles = 1'b1;
  bit sink_idles   = 1'b1;
  int hold_request = 0;
  int cycle_count  = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: a hung handshake must not leave the run spinning for ever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("two_pool_bitmap_block_allocator verification failed");
      $finish;
    end
  end

  // Result sink. Ready changes on the falling edge: mostly at random, never
  // while idling is switched off, and held low throughout a requested
  // hold-off so that the input register fills and the block stalls its input.
  initial begin
    int hold_left;
    hold_left      = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
      end else begin
        out_chan.ready <= !(sink_idles && $urandom_range(99) < 27);
      end
    end
  end

  // Every result transfer is checked on the rising edge at which it happens.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      sb.check_result(out_chan.status, out_chan.pool, out_chan.block_index,
                      out_chan.block_address);
    end
  end

  // Offers one request, starting at a falling edge, and returns at the falling
  // edge after its transfer. Valid is only dropped when an idle cycle is
  // chosen, so back-to-back transfers keep it high without a glitch.
  task automatic send_request(input cmd_e_t command, input logic [SIZE_W-1:0] size,
                              input logic [ADDR_W-1:0] addr);
    while (source_idles && $urandom_range(99) < 27) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.command      <= command;
    in_chan.request_size <= size;
    in_chan.free_address <= addr;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    sb.note_request(command, size, addr);
    @(negedge clk);
  endtask

  // Drops valid and waits until every owed answer has arrived, then lets the
  // two-stage pipeline settle.
  task automatic drain_pipeline();
    in_chan.valid <= 1'b0;
    while (sb.owed() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // Register writes happen only with the pipeline empty. Valid stays high
  // afterwards so that writes can follow one another; the caller drops it.
  task automatic write_register(input cfg_reg_e_t reg_sel, input logic [ADDR_W-1:0] value);
    cfg_chan.valid     <= 1'b1;
    cfg_chan.reg_index <= reg_sel;
    cfg_chan.wdata     <= value;
    do @(posedge clk); while (cfg_chan.ready !== 1'b1);
    sb.write_base(reg_sel, value);
    @(negedge clk);
  endtask

  task automatic set_bases(input logic [ADDR_W-1:0] small_value,
                           input logic [ADDR_W-1:0] big_value);
    drain_pipeline();
    write_register(CFG_SMALL_BASE, small_value);
    write_register(CFG_BIG_BASE, big_value);
    cfg_chan.valid <= 1'b0;
  endtask

  // Sizes lean towards the two valid bands and their edges, with some bad
  // sizes, including ones that set the upper bits of the field.
  function automatic logic [SIZE_W-1:0] pick_size();
    int roll;
    roll = $urandom_range(99);
    if (roll < 45) return SIZE_W'($urandom_range(SMALL_BYTES, 1));
    if (roll < 80) return SIZE_W'($urandom_range(BIG_BYTES, SMALL_BYTES + 1));
    if (roll < 86) begin
      case ($urandom_range(3))
        0: return SIZE_W'(1);
        1: return SIZE_W'(SMALL_BYTES);
        2: return SIZE_W'(SMALL_BYTES + 1);
        default: return SIZE_W'(BIG_BYTES);
      endcase
    end
    if (roll < 90) return '0;
    if (roll < 95) return SIZE_W'($urandom_range(16'hFFFF, BIG_BYTES + 1));
    return SIZE_W'($urandom);
  endfunction

  // Free addresses mostly hit a block start of either pool under the current
  // bases (a few indexes run past the pool end), some miss a start by a few
  // bytes, and the rest are noise over the whole address space.
  function automatic logic [ADDR_W-1:0] pick_free_address();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return sb.small_addr($urandom_range(SMALL_COUNT + 3, 0));
    if (roll < 72) return sb.big_addr($urandom_range(BIG_COUNT + 3, 0));
    if (roll < 82) begin
      if ($urandom_range(1) == 1) return sb.small_addr($urandom_range(SMALL_COUNT - 1, 0))
                                         + ADDR_W'($urandom_range(3, 1));
      return sb.big_addr($urandom_range(BIG_COUNT - 1, 0)) - ADDR_W'($urandom_range(3, 1));
    end
    return $urandom;
  endfunction

  // Random traffic in bursts: filling bursts are mostly allocations and
  // emptying bursts mostly frees, so both pools swing between empty and full.
  // The field that a command ignores is always random.
  task automatic run_traffic(input int item_count);
    int sent;
    int burst;
    int alloc_pct;
    sent = 0;
    while (sent < item_count) begin
      burst     = $urandom_range(40, 8);
      alloc_pct = ($urandom_range(1) == 1) ? 85 : 25;
      repeat (burst) begin
        send_request(($urandom_range(99) < alloc_pct) ? CMD_ALLOC : CMD_FREE,
                     pick_size(), pick_free_address());
        sent++;
      end
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.command    = CMD_ALLOC;
    in_chan.request_size = '0;
    in_chan.free_address = '0;
    cfg_chan.valid     = 1'b0;
    cfg_chan.reg_index = CFG_SMALL_BASE;
    cfg_chan.wdata     = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part with both bases at their reset value of zero, so the
    // pools overlap: every third small block starts where a big block does.
    send_request(CMD_ALLOC, 16'd0, 32'h0);              // zero size fails
    send_request(CMD_ALLOC, 16'(BIG_BYTES + 1), 32'h0); // just too big
    send_request(CMD_ALLOC, 16'hFFFF, 32'hFFFF_FFFF);   // largest size fails
    send_request(CMD_ALLOC, 16'd1, 32'h0);              // smallest valid size
    send_request(CMD_ALLOC, 16'(SMALL_BYTES), 32'h0);   // top of the small band
    send_request(CMD_ALLOC, 16'(SMALL_BYTES + 1), 32'h0);
    send_request(CMD_ALLOC, 16'(BIG_BYTES), 32'h0);     // top of the big band
    send_request(CMD_FREE, 16'hFFFF, 32'h0);            // shared start, small pool wins
    send_request(CMD_FREE, 16'h0, 32'h0);               // freeing a block already free
    send_request(CMD_FREE, 16'h0, 32'(BIG_BYTES));      // overlap again, small block 3
    send_request(CMD_FREE, 16'h0, 32'(BIG_BYTES * 11)); // past the small pool: big block
    send_request(CMD_FREE, 16'h0, 32'(BIG_BYTES + 1));  // no block starts here
    send_request(CMD_FREE, 16'h0, 32'hFFFF_FFFF);

    // Small requests until the small pool is full, then spill into the big
    // pool until that is full too, and then fail.
    repeat (SMALL_COUNT + BIG_COUNT + 2)
      send_request(CMD_ALLOC, 16'($urandom_range(SMALL_BYTES, 1)), $urandom);

    // Long sink hold-off while requests keep coming.
    hold_request = HOLD_CYCLES;
    run_traffic(120);

    // Bases near the top of the address space, so block addresses wrap.
    // This phase also runs with no idling on either side.
    set_bases(32'hFFFF_FF00, 32'hFFFF_F000);
    source_idles = 1'b0;
    sink_idles   = 1'b0;
    run_traffic(110);
    source_idles = 1'b1;
    sink_idles   = 1'b1;

    set_bases(32'hFFFF_FFFF, 32'h0000_0000);
    run_traffic(110);

    // Equal bases: the pools overlap from block zero on.
    set_bases(32'h1000_0000, 32'h1000_0000);
    hold_request = HOLD_CYCLES;
    run_traffic(110);

    set_bases($urandom, $urandom);
    run_traffic(110);

    // End of stimulus: collect the remaining answers.
    in_chan.valid <= 1'b0;
    while (sb.owed() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.owed() != 0) begin
      $error("%0d answers never arrived", sb.owed());
      sb.failures++;
    end
    if (sb.failures == 0) begin
      $display("two_pool_bitmap_block_allocator verification clean");
    end else begin
      $display("two_pool_bitmap_block_allocator verification failed");
    end
    $finish;
  end

endmodule
